// ===== rtl/core/tpbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbp_pkg
// shared constants, codes and controller/datapath link types for the plotter
// ----------------------------------------------------------------------------
package tpbp_pkg;

	// grid geometry
	localparam int GRID_SIZE = 64;
	localparam int MEM_ROWS  = 64;   // bitmap storage depth, one row per entry
	localparam int POS_W     = 6;
	localparam int ROW_W     = 64;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(GRID_SIZE - 1);

	// command codes
	localparam logic [2:0] CMD_PEN_UP     = 3'd0;
	localparam logic [2:0] CMD_PEN_DOWN   = 3'd1;
	localparam logic [2:0] CMD_TURN_RIGHT = 3'd2;
	localparam logic [2:0] CMD_TURN_LEFT  = 3'd3;
	localparam logic [2:0] CMD_FORWARD    = 3'd4;
	localparam logic [2:0] CMD_READ_ROW   = 3'd5;

	// heading codes
	localparam logic [1:0] HEAD_EAST  = 2'd0;
	localparam logic [1:0] HEAD_NORTH = 2'd1;
	localparam logic [1:0] HEAD_WEST  = 2'd2;
	localparam logic [1:0] HEAD_SOUTH = 2'd3;

	localparam logic [1:0] TURN_RIGHT_INC = 2'd3;
	localparam logic [1:0] TURN_LEFT_INC  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_STEP,
		ST_PAINT,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // latch the incoming command
		logic apply;    // pen and heading update
		logic step;     // take one forward step
		logic block;    // step refused at the border
		logic paint;    // write back the painted row
		logic finish;   // load the result register
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_fwd;
		logic steps_zero;
		logic blocked;
		logic pen;
		logic last_step;
		logic cnt_zero;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/tpbp_if.sv =====
// ----------------------------------------------------------------------------
// tpbp channel interfaces
// valid/ready channels for plotter commands and results
// ----------------------------------------------------------------------------
interface tpbp_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [5:0] steps;
	logic [5:0] row_index;

	modport source (output valid, command, steps, row_index, input ready);
	modport sink (input valid, command, steps, row_index, output ready);
endinterface

interface tpbp_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] row_bits;
	logic [5:0]  pos_row;
	logic [5:0]  pos_col;
	logic [1:0]  heading;
	logic        pen_is_down;
	logic        hit_edge;

	modport source (output valid, row_bits, pos_row, pos_col, heading, pen_is_down, hit_edge,
		input ready);
	modport sink (input valid, row_bits, pos_row, pos_col, heading, pen_is_down, hit_edge,
		output ready);
endinterface

// ===== rtl/core/tpbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpbp_ctrl
// command sequencer: dispatch, step/paint loop and result hand-off
// ----------------------------------------------------------------------------
module tpbp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tpbp_pkg::stat_t stat,
	output tpbp_pkg::ctl_t  ctl
);

	tpbp_pkg::state_t state_q;
	tpbp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			tpbp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = tpbp_pkg::ST_DISPATCH;
				end
			end
			tpbp_pkg::ST_DISPATCH: begin
				ctl.apply = 1'b1;
				if (stat.is_fwd && !stat.steps_zero) begin
					state_d = tpbp_pkg::ST_STEP;
				end else begin
					state_d = tpbp_pkg::ST_FINISH;
				end
			end
			tpbp_pkg::ST_STEP: begin
				if (stat.blocked) begin
					ctl.block = 1'b1;
					state_d   = tpbp_pkg::ST_FINISH;
				end else begin
					ctl.step = 1'b1;
					if (stat.pen) begin
						state_d = tpbp_pkg::ST_PAINT;
					end else if (stat.last_step) begin
						state_d = tpbp_pkg::ST_FINISH;
					end
				end
			end
			tpbp_pkg::ST_PAINT: begin
				ctl.paint = 1'b1;
				if (stat.cnt_zero) begin
					state_d = tpbp_pkg::ST_FINISH;
				end else begin
					state_d = tpbp_pkg::ST_STEP;
				end
			end
			tpbp_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					ctl.finish = 1'b1;
					state_d    = tpbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpbp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/tpbp_datapath.sv =====
// ----------------------------------------------------------------------------
// tpbp_datapath
// turtle state, bitmap row memory and result register
// ----------------------------------------------------------------------------
module tpbp_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  tpbp_pkg::ctl_t  ctl,
	output tpbp_pkg::stat_t stat,
	input  logic [2:0]      in_command,
	input  logic [5:0]      in_steps,
	input  logic [5:0]      in_row_index,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [63:0]     out_row_bits,
	output logic [5:0]      out_pos_row,
	output logic [5:0]      out_pos_col,
	output logic [1:0]      out_heading,
	output logic            out_pen_is_down,
	output logic            out_hit_edge
);

	// latched command
	logic [2:0]                   cmd_q;
	logic [tpbp_pkg::POS_W-1:0]   cnt_q;
	logic [tpbp_pkg::POS_W-1:0]   ridx_q;
	logic                         hit_q;

	// turtle state
	logic [tpbp_pkg::POS_W-1:0]   row_q;
	logic [tpbp_pkg::POS_W-1:0]   col_q;
	logic [1:0]                   head_q;
	logic                         pen_q;

	// bitmap storage
	logic [tpbp_pkg::ROW_W-1:0]   mem [tpbp_pkg::MEM_ROWS];
	logic [tpbp_pkg::MEM_ROWS-1:0] row_valid_q;
	logic [tpbp_pkg::ROW_W-1:0]   rdata_q;
	logic                         rvalid_q;
	logic [tpbp_pkg::POS_W-1:0]   rd_addr;
	logic [tpbp_pkg::ROW_W-1:0]   wdata;

	// next position
	logic [tpbp_pkg::POS_W-1:0]   nxt_row;
	logic [tpbp_pkg::POS_W-1:0]   nxt_col;
	logic                         blocked;

	logic                         out_valid_q;
	logic                         out_free;
	logic                         in_range;
	logic [tpbp_pkg::ROW_W-1:0]   read_bits;

	always_comb begin
		nxt_row = row_q;
		nxt_col = col_q;
		blocked = 1'b0;
		case (head_q)
			tpbp_pkg::HEAD_EAST: begin
				blocked = (col_q >= tpbp_pkg::LAST_POS);
				nxt_col = col_q + 6'd1;
			end
			tpbp_pkg::HEAD_NORTH: begin
				blocked = (row_q == '0);
				nxt_row = row_q - 6'd1;
			end
			tpbp_pkg::HEAD_WEST: begin
				blocked = (col_q == '0);
				nxt_col = col_q - 6'd1;
			end
			default: begin
				blocked = (row_q >= tpbp_pkg::LAST_POS);
				nxt_row = row_q + 6'd1;
			end
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat.is_fwd     = (cmd_q == tpbp_pkg::CMD_FORWARD);
		stat.steps_zero = (cnt_q == '0);
		stat.blocked    = blocked;
		stat.pen        = pen_q;
		stat.last_step  = (cnt_q == 6'd1);
		stat.cnt_zero   = (cnt_q == '0);
		stat.out_free   = out_free;
	end

	// a step reads the row it enters, otherwise the row asked for by a read
	assign rd_addr = ctl.step ? nxt_row : ridx_q;
	assign wdata   = (rvalid_q ? rdata_q : '0) | (64'd1 << col_q);

	always_ff @(posedge clk) begin
		if (ctl.paint) begin
			mem[row_q] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			head_q      <= tpbp_pkg::HEAD_EAST;
			pen_q       <= 1'b0;
			cmd_q       <= tpbp_pkg::CMD_PEN_UP;
			cnt_q       <= '0;
			ridx_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_q <= row_valid_q[rd_addr];
			if (ctl.paint) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (ctl.load) begin
				cmd_q  <= in_command;
				cnt_q  <= in_steps;
				ridx_q <= in_row_index;
				hit_q  <= 1'b0;
			end
			if (ctl.apply) begin
				case (cmd_q)
					tpbp_pkg::CMD_PEN_UP:     pen_q  <= 1'b0;
					tpbp_pkg::CMD_PEN_DOWN:   pen_q  <= 1'b1;
					tpbp_pkg::CMD_TURN_RIGHT: head_q <= head_q + tpbp_pkg::TURN_RIGHT_INC;
					tpbp_pkg::CMD_TURN_LEFT:  head_q <= head_q + tpbp_pkg::TURN_LEFT_INC;
					default: ;
				endcase
			end
			if (ctl.step) begin
				row_q <= nxt_row;
				col_q <= nxt_col;
				cnt_q <= cnt_q - 6'd1;
			end
			if (ctl.block) begin
				hit_q <= 1'b1;
			end
			if (ctl.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_range  = ({1'b0, ridx_q} < 7'(tpbp_pkg::GRID_SIZE));
	assign read_bits = (cmd_q == tpbp_pkg::CMD_READ_ROW && in_range && rvalid_q) ?
		rdata_q : '0;

	// result payload
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_row_bits    <= read_bits;
			out_pos_row     <= row_q;
			out_pos_col     <= col_q;
			out_heading     <= head_q;
			out_pen_is_down <= pen_q;
			out_hit_edge    <= hit_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/turtle_pen_bitmap_plotter.sv =====
// ----------------------------------------------------------------------------
// turtle_pen_bitmap_plotter
// turtle plotter over a 64 by 64 one-bit bitmap with a row read-back command
// ----------------------------------------------------------------------------
// A command is taken on the cmd channel when the plotter is idle and gives
// exactly one result on res. Pen up, pen down, turns, read row and unused
// codes pass from dispatch straight to finish. A forward move runs a step
// state for each step, each followed by a paint state when the pen is down,
// and ends early if the border stops it; each painted step is a
// read-modify-write of one row through the bitmap memory, which has one
// read and one write port. The bitmap holds one valid flag per row, cleared
// by reset, so no clearing pass is needed after reset. A new command is
// taken while the previous result still waits in the output register.
module turtle_pen_bitmap_plotter (
	input  logic        clk,
	input  logic        arst_n,
	tpbp_cmd_if.sink    cmd,
	tpbp_res_if.source  res
);

	// controller/datapath link
	tpbp_pkg::ctl_t  ctl;
	tpbp_pkg::stat_t stat;

	// sequencer: decides which datapath operation runs each cycle
	tpbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// turtle state, bitmap and result register
	tpbp_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.in_command      (cmd.command),
		.in_steps        (cmd.steps),
		.in_row_index    (cmd.row_index),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.out_row_bits    (res.row_bits),
		.out_pos_row     (res.pos_row),
		.out_pos_col     (res.pos_col),
		.out_heading     (res.heading),
		.out_pen_is_down (res.pen_is_down),
		.out_hit_edge    (res.hit_edge)
	);

endmodule
